/* sv/a2bc_pkg.sv */
// ----------------------------------------------------------------------------
// a2bc_pkg: shared types and constants for the Argon2 block compression.
// Defines the beat structs, the controller command/status structs and the
// multiply-add helper.
// ----------------------------------------------------------------------------
package a2bc_pkg;

  localparam int unsigned WORDS   = 128;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned WORD_W  = 64;

  typedef struct packed {
    logic [63:0] prev_word;
    logic [63:0] ref_word;
    logic [63:0] old_word;
    logic        accumulate;
  } in_item_t;

  typedef struct packed {
    logic [63:0] even_word;
    logic [63:0] odd_word;
    logic        last_pair;
  } out_item_t;

  // Datapath operation codes issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_RDA   = 3'd2,
    OP_MIX   = 3'd3,
    OP_WRB   = 3'd4,
    OP_EMIT  = 3'd5
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] addr;
    logic [1:0]       slot;
    logic [2:0]       mix_step;
    logic             first;
  } dp_cmd_t;

  typedef struct packed {
    logic mix_done;
  } dp_status_t;

  // Multiply-add step: a + b + 2 * p, where p is the product lo32(a) * lo32(b).
  function automatic logic [63:0] mul_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] p);
    mul_add = a + b + {p[62:0], 1'b0};
  endfunction

endpackage

/* sv/a2bc_ram.sv */
// ----------------------------------------------------------------------------
// a2bc_ram: generic single-port-write, single-port-read RAM.
// Read data is registered.
// ----------------------------------------------------------------------------
module a2bc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/a2bc_datapath.sv */
// ----------------------------------------------------------------------------
// a2bc_datapath: buffers and shared mixing unit.
// Holds work and feedback memories, four mix operand registers and one
// 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module a2bc_datapath (
  input  logic                clk,
  input  a2bc_pkg::dp_cmd_t   cmd,
  input  a2bc_pkg::in_item_t  in_item,
  input  logic                acc_flag,
  output a2bc_pkg::dp_status_t status,
  output logic [63:0]         out_word
);
  import a2bc_pkg::*;

  logic [63:0] v [4];
  logic [63:0] prod;
  logic [63:0] wrk_rdata, fb_rdata;
  logic        wrk_we;
  logic [IDX_W-1:0] wrk_waddr;
  logic [63:0] wrk_wdata;
  logic [63:0] r_word;
  logic [63:0] ma;
  logic        rd_pending;
  logic [1:0]  rd_slot;
  logic [63:0] ax, bx;
  logic [1:0]  ia, ib;

  assign r_word = in_item.prev_word ^ in_item.ref_word;

  // Work buffer writes come from loading or from mix write-back.
  always_comb begin
    wrk_we    = 1'b0;
    wrk_waddr = cmd.addr;
    wrk_wdata = r_word;
    if (cmd.op == OP_LOAD) begin
      wrk_we = 1'b1;
    end else if (cmd.op == OP_WRB) begin
      wrk_we    = 1'b1;
      wrk_wdata = v[cmd.slot];
    end
  end

  a2bc_ram #(.WIDTH(64), .DEPTH(128)) u_work (
    .clk(clk), .we(wrk_we), .waddr(wrk_waddr), .wdata(wrk_wdata),
    .raddr(cmd.addr), .rdata(wrk_rdata)
  );

  a2bc_ram #(.WIDTH(64), .DEPTH(128)) u_fb (
    .clk(clk), .we(cmd.op == OP_LOAD), .waddr(cmd.addr),
    .wdata(acc_flag ? (r_word ^ in_item.old_word) : r_word),
    .raddr(cmd.addr), .rdata(fb_rdata)
  );

  assign out_word = wrk_rdata ^ fb_rdata;

  // Mix sub-step operand selection: even steps are multiply-add (a+=b or
  // c+=d), odd steps are xor-rotate (d or b).
  always_comb begin
    case (cmd.mix_step[2:1])
      2'd0:    begin ia = 2'd0; ib = 2'd1; end
      2'd1:    begin ia = 2'd2; ib = 2'd3; end
      2'd2:    begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd2; ib = 2'd3; end
    endcase
    ax = v[ia];
    bx = v[ib];
    ma = mul_add(ax, bx, prod);
  end

  assign status.mix_done = (cmd.op == OP_MIX) && (cmd.mix_step == 3'd7) && cmd.first;

  // Operand registers: capture reads, then run the mix in sub-steps.
  // Each sub-step first registers the product, then applies it.
  always_ff @(posedge clk) begin
    rd_pending <= (cmd.op == OP_RDA);
    rd_slot    <= cmd.slot;
    prod       <= {32'd0, ax[31:0]} * {32'd0, bx[31:0]};
    if (rd_pending) begin
      v[rd_slot] <= wrk_rdata;
    end
    if (cmd.op == OP_MIX && cmd.first) begin
      case (cmd.mix_step)
        3'd0, 3'd4: v[0] <= ma;
        3'd2, 3'd6: v[2] <= ma;
        3'd1:       v[3] <= {v[3] ^ v[0]} >> 32 | {v[3] ^ v[0]} << 32;
        3'd3:       v[1] <= (v[1] ^ v[2]) >> 24 | (v[1] ^ v[2]) << 40;
        3'd5:       v[3] <= (v[3] ^ v[0]) >> 16 | (v[3] ^ v[0]) << 48;
        default:    v[1] <= (v[1] ^ v[2]) >> 63 | (v[1] ^ v[2]) << 1;
      endcase
    end
  end

endmodule

/* sv/a2bc_ctrl.sv */
// ----------------------------------------------------------------------------
// a2bc_ctrl: sequencer for load, permutation and emission.
// Walks 128 loads, then 128 mixes (read four, mix, write four), then
// 64 output pairs.
// ----------------------------------------------------------------------------
module a2bc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 accumulate,
  output logic                 acc_flag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 last_pair,
  output logic                 even_phase,
  output a2bc_pkg::dp_cmd_t    cmd,
  input  a2bc_pkg::dp_status_t status
);
  import a2bc_pkg::*;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_RD   = 6'b000010,
    ST_MIX  = 6'b000100,
    ST_WR   = 6'b001000,
    ST_ERD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t      state;
  logic [6:0]  word_count;
  logic        acc_reg;
  logic [6:0]  mix_idx;     // round (4 bits) and mix within round (3 bits)
  logic [2:0]  step;
  logic        half;
  logic [2:0]  sub;         // read/write slot counter, with wait beats after the reads
  logic [5:0]  pair;
  logic [1:0]  ephase;
  logic [3:0]  pidx [4];
  logic [IDX_W-1:0] word_addr [4];
  logic [3:0]  rnd;
  logic [2:0]  mx;
  logic [2:0]  grp;
  logic [1:0]  slot;

  assign rnd = mix_idx[6:3];
  assign mx  = mix_idx[2:0];
  assign grp = rnd[2:0];
  assign slot = sub[1:0];

  // Index pattern of the current mix within its 16-word round.
  always_comb begin
    pidx[0] = 4'(mx[1:0]);
    if (!mx[2]) begin
      pidx[1] = 4'(4 + mx[1:0]);
      pidx[2] = 4'(8 + mx[1:0]);
      pidx[3] = 4'(12 + mx[1:0]);
    end else begin
      pidx[1] = 4'(4 + ((mx[1:0] + 2'd1) & 2'd3));
      pidx[2] = 4'(8 + ((mx[1:0] + 2'd2) & 2'd3));
      pidx[3] = 4'(12 + ((mx[1:0] + 2'd3) & 2'd3));
    end
    for (int k = 0; k < 4; k++) begin
      if (!rnd[3]) begin
        word_addr[k] = {grp, pidx[k]};
      end else begin
        word_addr[k] = {pidx[k][3:1], grp, pidx[k][0]};
      end
    end
  end

  assign in_ready   = (state == ST_LOAD);
  assign acc_flag   = (word_count == 7'd0) ? accumulate : acc_reg;
  assign out_valid  = (state == ST_OUT);
  assign last_pair  = (pair == 6'd63);
  assign even_phase = ephase[0];

  // Command generation.
  always_comb begin
    cmd = '0;
    cmd.op = OP_NONE;
    case (state)
      ST_LOAD: begin
        cmd.op   = (in_valid) ? OP_LOAD : OP_NONE;
        cmd.addr = word_count;
      end
      ST_RD: begin
        cmd.op   = (sub < 3'd4) ? OP_RDA : OP_NONE;
        cmd.addr = word_addr[slot];
        cmd.slot = slot;
      end
      ST_MIX: begin
        cmd.op       = OP_MIX;
        cmd.mix_step = step;
        cmd.first    = half;
      end
      ST_WR: begin
        cmd.op   = OP_WRB;
        cmd.addr = word_addr[slot];
        cmd.slot = slot;
      end
      ST_ERD: begin
        cmd.op   = OP_EMIT;
        cmd.addr = {pair, ephase[1]};
      end
      ST_OUT: begin
        cmd.op   = OP_EMIT;
        cmd.addr = {pair, 1'b1};
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      word_count <= '0;
      acc_reg    <= 1'b0;
      mix_idx    <= '0;
      step       <= '0;
      half       <= 1'b0;
      sub        <= '0;
      pair       <= '0;
      ephase     <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (word_count == 7'd0) begin
              acc_reg <= accumulate;
            end
            word_count <= word_count + 7'd1;
            if (word_count == 7'd127) begin
              state   <= ST_RD;
              mix_idx <= '0;
              sub     <= '0;
            end
          end
        end
        ST_RD: begin
          sub <= sub + 3'd1;
          if (sub == 3'd5) begin
            state <= ST_MIX;
            step  <= '0;
            half  <= 1'b0;
          end
        end
        ST_MIX: begin
          half <= ~half;
          if (half) begin
            step <= step + 3'd1;
            if (status.mix_done) begin
              state <= ST_WR;
              sub   <= '0;
            end
          end
        end
        ST_WR: begin
          if (sub == 3'd3) begin
            sub     <= '0;
            mix_idx <= mix_idx + 7'd1;
            if (mix_idx == 7'd127) begin
              state  <= ST_ERD;
              pair   <= '0;
              ephase <= '0;
            end else begin
              state <= ST_RD;
            end
          end else begin
            sub <= sub + 3'd1;
          end
        end
        ST_ERD: begin
          ephase <= ephase + 2'd1;
          if (ephase == 2'd2) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            pair   <= pair + 6'd1;
            ephase <= '0;
            state  <= (pair == 6'd63) ? ST_LOAD : ST_ERD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* sv/argon2_block_compression.sv */
// ----------------------------------------------------------------------------
// argon2_block_compression: Argon2 compression function G.
// Loads 128 words, permutes them with 16 BLAKE2b rounds and emits 64 pairs.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  in      | input     | in_item_t   | in_valid / in_ready
//  out     | output    | out_item_t  | out_valid / out_ready
//
// One input beat per cycle while loading. The permutation then runs 128
// mixes on one shared multiply-add unit; each mix reads four words, runs
// its sub-steps and writes four words back. Each output pair is read
// through the registered memory read ports. Input is not taken during the
// permutation or emission. Reset clears only the sequencer.
module argon2_block_compression (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  a2bc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output a2bc_pkg::out_item_t  out_data
);
  import a2bc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       acc_flag;
  logic       last_pair;
  logic       even_phase;
  logic [63:0] out_word;
  logic [63:0] even_hold;

  a2bc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .accumulate(in_data.accumulate), .acc_flag(acc_flag),
    .out_valid(out_valid), .out_ready(out_ready), .last_pair(last_pair),
    .even_phase(even_phase), .cmd(cmd), .status(status)
  );

  a2bc_datapath u_dp (
    .clk(clk), .cmd(cmd), .in_item(in_data), .acc_flag(acc_flag),
    .status(status), .out_word(out_word)
  );

  // Hold the even word while the odd word is read.
  always_ff @(posedge clk) begin
    if (even_phase && !out_valid) begin
      even_hold <= out_word;
    end
  end

  assign out_data.even_word = even_hold;
  assign out_data.odd_word  = out_word;
  assign out_data.last_pair = last_pair;

  // Input and output are never active together.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output active together");
  // A held output beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output beat changed while stalled");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Argon2 block compression testbench
// Streams blocks of 128 word beats into the compression core, predicts the
// 64 output pairs of each block with a local model of the permutation, and
// compares every output beat with the oldest predicted pair. Idle and stall
// patterns change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  import a2bc_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  argon2_block_compression u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state.
  logic [63:0] work_words [0:127];
  logic [63:0] fold_words [0:127];
  int unsigned word_index;
  logic        accum_mode;
  out_item_t   pending_pairs [$];

  int unsigned error_count;
  int unsigned idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Directed rows: the word pattern of one beat within a block.
  typedef struct packed {
    logic [63:0] prev_word;
    logic [63:0] ref_word;
    logic [63:0] old_word;
    logic        accumulate;
  } stim_row_t;
  stim_row_t directed_rows [0:5];

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  function automatic logic [63:0] blamka(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] prod;
    prod = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    return a + b + (prod << 1);
  endfunction

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic mix_quad(input int ia, input int ib, input int ic, input int id);
    logic [63:0] a, b, c, d;
    a = work_words[ia]; b = work_words[ib]; c = work_words[ic]; d = work_words[id];
    a = blamka(a, b); d = ror64(d ^ a, 32);
    c = blamka(c, d); b = ror64(b ^ c, 24);
    a = blamka(a, b); d = ror64(d ^ a, 16);
    c = blamka(c, d); b = ror64(b ^ c, 63);
    work_words[ia] = a; work_words[ib] = b; work_words[ic] = c; work_words[id] = d;
  endtask

  task automatic blake_round(input int p [16]);
    mix_quad(p[0], p[4], p[8],  p[12]);
    mix_quad(p[1], p[5], p[9],  p[13]);
    mix_quad(p[2], p[6], p[10], p[14]);
    mix_quad(p[3], p[7], p[11], p[15]);
    mix_quad(p[0], p[5], p[10], p[15]);
    mix_quad(p[1], p[6], p[11], p[12]);
    mix_quad(p[2], p[7], p[8],  p[13]);
    mix_quad(p[3], p[4], p[9],  p[14]);
  endtask

  // Take one accepted word; after the last word of a block, queue 64 pairs.
  task automatic predict_word(input in_item_t beat);
    int p [16];
    logic [63:0] r;
    out_item_t pair;
    if (word_index == 0) accum_mode = beat.accumulate;
    r = beat.prev_word ^ beat.ref_word;
    work_words[word_index] = r;
    fold_words[word_index] = accum_mode ? (r ^ beat.old_word) : r;
    if (word_index != WORDS - 1) begin
      word_index++;
      return;
    end
    word_index = 0;
    // Rows of 16 consecutive words, then interleaved columns.
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 16; j++) p[j] = i * 16 + j;
      blake_round(p);
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        p[2 * j]     = i * 2 + j * 16;
        p[2 * j + 1] = i * 2 + j * 16 + 1;
      end
      blake_round(p);
    end
    for (int k = 0; k < 64; k++) begin
      pair.even_word = work_words[2 * k] ^ fold_words[2 * k];
      pair.odd_word  = work_words[2 * k + 1] ^ fold_words[2 * k + 1];
      pair.last_pair = (k == 63);
      pending_pairs.push_back(pair);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_edge64();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Drive one beat and hold it until accepted. Valid drops only for idle
  // cycles, so beats follow without a gap when the sender does not idle.
  task automatic send_word(input in_item_t beat);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(beat);
  endtask

  // Send a run of words: the directed rows in turn, or random words. The
  // accumulate flag of the first word of a block is taken from acc.
  task automatic send_words(input bit directed, input int count, input logic acc);
    in_item_t beat;
    for (int w = 0; w < count; w++) begin
      if (directed) begin
        beat = directed_rows[word_index % 6];
      end else begin
        beat.prev_word  = rand_edge64();
        beat.ref_word   = rand_edge64();
        beat.old_word   = rand_edge64();
        beat.accumulate = 1'($urandom_range(0, 1));
      end
      if (word_index == 0) beat.accumulate = acc;
      send_word(beat);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver: random stalls and checking of every output beat.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pairs.size() == 0) begin
          report_mismatch("unexpected pair", out_data.even_word, 64'd0);
        end else begin
          if (out_data.even_word !== pending_pairs[0].even_word)
            report_mismatch("even_word", out_data.even_word, pending_pairs[0].even_word);
          if (out_data.odd_word !== pending_pairs[0].odd_word)
            report_mismatch("odd_word", out_data.odd_word, pending_pairs[0].odd_word);
          if (out_data.last_pair !== pending_pairs[0].last_pair)
            report_mismatch("last_pair", 64'(out_data.last_pair),
                            64'(pending_pairs[0].last_pair));
          void'(pending_pairs.pop_front());
        end
      end
      out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    word_index = 0;
    accum_mode = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Extremes: all zeros, all ones, prev/ref cancelling, old word ignored.
    directed_rows[0] = '{64'd0, 64'd0, 64'd0, 1'b0};
    directed_rows[1] = '{'1, 64'd0, '1, 1'b1};
    directed_rows[2] = '{'1, '1, '1, 1'b1};
    directed_rows[3] = '{64'h8000_0000_0000_0001, 64'h0000_0001_FFFF_FFFF, '1, 1'b0};
    directed_rows[4] = '{64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'd0, 1'b1};
    directed_rows[5] = '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                         64'h5555_AAAA_5555_AAAA, 1'b0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two blocks: the directed rows walked in turn, then random words in
    // accumulate mode. The idle pattern changes every half block.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      send_words(ph < 2, WORDS / 2, (ph < 2) ? directed_rows[0].accumulate : 1'b1);
    end
    drain();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
